// ===== rtl/gg_pkg.sv =====
// Shared types, constants and elaboration-time helper functions for the
// grayscale gamma correction block. Depends on nothing else.
`timescale 1ns / 1ps

package gg_pkg;

  localparam int GRAY_FRAC_BITS = 8;
  localparam int CHAN_W         = 8;
  localparam int WEIGHT_W       = 16;
  localparam int GAMMA_W        = 24;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 24;
  localparam int LOG_FRAC_W     = 30;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_WEIGHT_RED,
    REG_WEIGHT_GREEN,
    REG_WEIGHT_BLUE,
    REG_GAMMA
  } reg_index_t;

  // Result override carried alongside each pixel.
  typedef enum logic [1:0] {
    CODE_NONE,
    CODE_ZERO,
    CODE_FULL
  } code_t;

  typedef struct packed {
    logic  last;
    code_t code;
  } side_t;

  // Integer square root of a 64-bit value.
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] xr;
    logic [63:0] r;
    logic [63:0] b;
    xr = x;
    r  = '0;
    b  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (xr >= r + b) begin
        xr = xr - (r + b);
        r  = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-k) in Q.30, by k repeated square roots of one half.
  function automatic logic [30:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int i = 1; i <= 30; i++) begin
      if (i <= k) begin
        c = isqrt64(c << 30);
      end
    end
    return c[30:0];
  endfunction

  // log2 of v in Q.30, squaring with truncation as the datapath does.
  function automatic logic [63:0] log2_q30(input logic [63:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] res;
    e = 0;
    for (int i = 1; i < 64; i++) begin
      if ((v >> i) != 64'd0) begin
        e = i;
      end
    end
    if (e <= 30) begin
      m = v << (30 - e);
    end else begin
      m = v >> (e - 30);
    end
    res = 64'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m      = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

// ===== rtl/gg_datapath.sv =====
// Pixel pipeline of the grayscale gamma correction block: weighted sum,
// divider, log2, exponent scaling and exp2. Depends on gg_pkg.
`timescale 1ns / 1ps

module gg_datapath #(
  parameter int GRAY_FRAC_BITS = gg_pkg::GRAY_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          advance,
  input  logic                          in_valid,
  input  logic [gg_pkg::CHAN_W-1:0]     red,
  input  logic [gg_pkg::CHAN_W-1:0]     green,
  input  logic [gg_pkg::CHAN_W-1:0]     blue,
  input  logic                          last_in,
  input  logic [gg_pkg::WEIGHT_W-1:0]   weight_red,
  input  logic [gg_pkg::WEIGHT_W-1:0]   weight_green,
  input  logic [gg_pkg::WEIGHT_W-1:0]   weight_blue,
  input  logic [gg_pkg::GAMMA_W-1:0]    gamma_exponent,
  output logic                          out_valid,
  output logic [gg_pkg::CHAN_W-1:0]     corrected_gray,
  output logic                          last_out
);

  localparam int F     = GRAY_FRAC_BITS;
  localparam int QW    = gg_pkg::CHAN_W + F;
  localparam int LF    = gg_pkg::LOG_FRAC_W;
  localparam int PRW   = gg_pkg::WEIGHT_W + gg_pkg::CHAN_W;
  localparam int SW    = PRW + 2;
  localparam int SUMW  = gg_pkg::WEIGHT_W + 2;
  localparam int DVW   = SW + F + 1;
  localparam int DSW   = SUMW + 1;
  localparam int EW    = $clog2(QW);
  localparam int LW    = EW + LF;
  localparam int GW    = LW + gg_pkg::GAMMA_W;
  localparam int PW    = GW - 16;
  localparam int TW    = LF + 1 + gg_pkg::CHAN_W;
  localparam logic [QW-1:0] FULL = QW'(255) << F;
  localparam logic [63:0] LA64 = gg_pkg::log2_q30(64'(FULL));
  localparam logic [LW-1:0] LA = LA64[LW-1:0];

  localparam int S_PROD  = 0;
  localparam int S_DVD   = 1;
  localparam int S_DIV0  = 2;
  localparam int S_NORM  = S_DIV0 + QW;
  localparam int S_LOG0  = S_NORM + 1;
  localparam int S_D     = S_LOG0 + LF;
  localparam int S_P     = S_D + 1;
  localparam int S_EXP0  = S_P + 1;
  localparam int S_SCALE = S_EXP0 + LF;
  localparam int S_OUT   = S_SCALE + 1;
  localparam int LAT     = S_OUT + 1;

  logic                  vld     [LAT];
  gg_pkg::side_t         sd      [LAT];
  gg_pkg::side_t         sd_next [LAT];

  // Valid bits and side information travel down one chain.
  for (genvar i = 0; i < LAT; i++) begin : g_chain
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (advance) begin
        vld[i] <= (i == 0) ? in_valid : vld[(i == 0) ? 0 : i - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (advance) begin
        sd[i] <= sd_next[i];
      end
    end
  end

  // Weighted products and weight sum.
  logic [PRW-1:0]  pr;
  logic [PRW-1:0]  pg;
  logic [PRW-1:0]  pb;
  logic [SUMW-1:0] wsum;
  logic [SUMW-1:0] wsum_next;

  assign wsum_next = SUMW'(weight_red) + SUMW'(weight_green) + SUMW'(weight_blue);

  always_comb begin
    sd_next[S_PROD].last = last_in;
    if (wsum_next == '0) begin
      sd_next[S_PROD].code = gg_pkg::CODE_ZERO;
    end else if (gamma_exponent == '0) begin
      sd_next[S_PROD].code = gg_pkg::CODE_FULL;
    end else begin
      sd_next[S_PROD].code = gg_pkg::CODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pr   <= PRW'(weight_red) * PRW'(red);
      pg   <= PRW'(weight_green) * PRW'(green);
      pb   <= PRW'(weight_blue) * PRW'(blue);
      wsum <= wsum_next;
    end
  end

  // Dividend (2s*2^F + sum) and divisor 2*sum for rounded division.
  logic [DVW-1:0] dvd;
  logic [DSW-1:0] dvs;
  logic [SW-1:0]  s_sum;

  assign s_sum = SW'(pr) + SW'(pg) + SW'(pb);
  assign sd_next[S_DVD] = sd[S_DVD-1];

  always_ff @(posedge clk) begin
    if (advance) begin
      dvd <= (DVW'(s_sum) << (F + 1)) + DVW'(wsum);
      dvs <= {wsum, 1'b0};
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic [DVW-1:0] div_rem [QW];
  logic [DSW-1:0] div_dvs [QW];
  logic [QW-1:0]  div_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_div
    logic [DVW-1:0] rem_in;
    logic [DSW-1:0] dvs_in;
    logic [QW-1:0]  q_in;
    logic [QW-1:0]  q_out;
    logic [DVW-1:0] shifted;
    logic           ge;

    assign rem_in  = (j == 0) ? dvd : div_rem[(j == 0) ? 0 : j - 1];
    assign dvs_in  = (j == 0) ? dvs : div_dvs[(j == 0) ? 0 : j - 1];
    assign q_in    = (j == 0) ? '0 : div_q[(j == 0) ? 0 : j - 1];
    assign shifted = DVW'(dvs_in) << (QW - 1 - j);
    assign ge      = rem_in >= shifted;
    assign sd_next[S_DIV0 + j] = sd[S_DIV0 + j - 1];

    always_comb begin
      q_out = q_in;
      q_out[QW - 1 - j] = ge;
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        div_rem[j] <= ge ? rem_in - shifted : rem_in;
        div_dvs[j] <= dvs_in;
        div_q[j]   <= q_out;
      end
    end
  end

  // Normalize the gray value to [1,2) in Q1.30.
  logic [QW-1:0] q_val;
  logic [EW-1:0] e_enc;
  logic [LF:0]   nm_m;
  logic [EW-1:0] nm_e;

  assign q_val = div_q[QW-1];

  always_comb begin
    e_enc = '0;
    for (int b = 1; b < QW; b++) begin
      if (q_val[b]) begin
        e_enc = EW'(b);
      end
    end
  end

  always_comb begin
    sd_next[S_NORM] = sd[S_NORM-1];
    if (sd[S_NORM-1].code == gg_pkg::CODE_NONE) begin
      if (q_val >= FULL) begin
        sd_next[S_NORM].code = gg_pkg::CODE_FULL;
      end else if (q_val == '0) begin
        sd_next[S_NORM].code = gg_pkg::CODE_ZERO;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      nm_m <= (LF + 1)'(q_val) << (LF - int'(e_enc));
      nm_e <= e_enc;
    end
  end

  // log2 fraction by repeated squaring, one bit per stage.
  logic [LF:0]   lg_m [LF];
  logic [LW-1:0] lg_r [LF];

  for (genvar j = 0; j < LF; j++) begin : g_log
    logic [LF:0]       m_in;
    logic [LW-1:0]     r_in;
    logic [2*LF+1:0]   sq;
    logic [LF+1:0]     t;
    logic [LW-1:0]     r_out;

    assign m_in = (j == 0) ? nm_m : lg_m[(j == 0) ? 0 : j - 1];
    assign r_in = (j == 0) ? {nm_e, LF'(0)} : lg_r[(j == 0) ? 0 : j - 1];
    assign sq   = (2*LF+2)'(m_in) * (2*LF+2)'(m_in);
    assign t    = sq[2*LF+1:LF];
    assign sd_next[S_LOG0 + j] = sd[S_LOG0 + j - 1];

    always_comb begin
      r_out = r_in;
      r_out[LF - 1 - j] = t[LF+1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        lg_m[j] <= t[LF+1] ? t[LF+1:1] : t[LF:0];
        lg_r[j] <= r_out;
      end
    end
  end

  // Distance from full white in log2 and its product with gamma.
  logic [LW-1:0] d_r;
  logic [PW-1:0] p_r;
  logic [GW-1:0] gprod;

  assign sd_next[S_D] = sd[S_D-1];
  assign sd_next[S_P] = sd[S_P-1];
  assign gprod = GW'(d_r) * GW'(gamma_exponent) + (GW'(1) << 15);

  always_ff @(posedge clk) begin
    if (advance) begin
      d_r <= (LA > lg_r[LF-1]) ? LA - lg_r[LF-1] : '0;
      p_r <= gprod[GW-1:16];
    end
  end

  // 2^-frac as a product of conditional coefficients, one per stage.
  logic [LF:0]   ex_v [LF];
  logic [LF-1:0] ex_f [LF];
  logic [4:0]    ex_n [LF];
  logic [PW-LF-1:0] n_full;

  assign n_full = p_r[PW-1:LF];

  for (genvar j = 0; j < LF; j++) begin : g_exp
    localparam logic [LF:0] COEF = gg_pkg::exp_coef(j + 1);
    logic [LF:0]     v_in;
    logic [LF-1:0]   f_in;
    logic [4:0]      n_in;
    logic [2*LF+1:0] mul;

    assign v_in = (j == 0) ? (LF + 1)'(1) << LF : ex_v[(j == 0) ? 0 : j - 1];
    assign f_in = (j == 0) ? p_r[LF-1:0] : ex_f[(j == 0) ? 0 : j - 1];
    assign n_in = (j == 0) ? n_full[4:0] : ex_n[(j == 0) ? 0 : j - 1];
    assign mul  = (2*LF+2)'(v_in) * (2*LF+2)'(COEF) + ((2*LF+2)'(1) << (LF - 1));

    if (j == 0) begin : g_first
      always_comb begin
        sd_next[S_EXP0] = sd[S_EXP0-1];
        if (sd[S_EXP0-1].code == gg_pkg::CODE_NONE && n_full > (PW-LF)'(30)) begin
          sd_next[S_EXP0].code = gg_pkg::CODE_ZERO;
        end
      end
    end else begin : g_rest
      assign sd_next[S_EXP0 + j] = sd[S_EXP0 + j - 1];
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        ex_v[j] <= f_in[LF - 1 - j] ? mul[2*LF:LF] : v_in;
        ex_f[j] <= f_in;
        ex_n[j] <= n_in;
      end
    end
  end

  // Scale by 255, then round and shift by the integer part.
  logic [TW-1:0] sc_t;
  logic [4:0]    sc_n;
  logic [63:0]   fin_sum;
  logic [63:0]   fin_shift;
  logic [gg_pkg::CHAN_W-1:0] og;

  assign sd_next[S_SCALE] = sd[S_SCALE-1];
  assign sd_next[S_OUT]   = sd[S_OUT-1];
  assign fin_sum   = 64'(sc_t) + (64'd1 << (LF - 1 + int'(sc_n)));
  assign fin_shift = fin_sum >> (LF + int'(sc_n));

  always_ff @(posedge clk) begin
    if (advance) begin
      sc_t <= TW'(ex_v[LF-1]) * TW'(255);
      sc_n <= ex_n[LF-1];
      case (sd[S_OUT-1].code)
        gg_pkg::CODE_ZERO: og <= '0;
        gg_pkg::CODE_FULL: og <= '1;
        gg_pkg::CODE_NONE: og <= (fin_shift > 64'd255) ? '1 : fin_shift[7:0];
        default:           og <= '0;
      endcase
    end
  end

  assign out_valid      = vld[LAT-1];
  assign last_out       = sd[LAT-1].last;
  assign corrected_gray = og;

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("pipeline holds a pixel right after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(og) && $stable(sd[LAT-1]))
    else $error("output stage changed while held");
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    advance && sd[S_OUT-1].code == gg_pkg::CODE_ZERO |=> og == '0)
    else $error("zero override not applied");

endmodule

// ===== rtl/grayscale_gamma_correct_top.sv =====
// Top level of the grayscale gamma correction block: configuration
// registers and stall control. Depends on gg_pkg and gg_datapath.
`timescale 1ns / 1ps

// Usage: one RGB pixel is taken per transfer on the pixel channel
// (pixel_valid / pixel_stall) and one gamma corrected gray byte leaves per
// transfer on the gray channel (gray_valid / gray_stall); last_out mirrors
// last_in of the same pixel. Each pixel goes through a fixed pipeline of
// 83 register stages (for the default 8 gray fraction bits): products,
// dividend, one stage per quotient bit of the divider, normalization, 30
// squaring stages for log2, the log2 distance from full white, the gamma
// multiply, 30 coefficient stages for exp2, the scale by 255 and the final
// round. A new pixel can be taken every cycle while pixel_stall is low.
// The whole pipeline moves as one when the output stage is empty or its
// gray byte is taken in that cycle; otherwise every stage holds, the
// output byte stays put and pixel_stall is raised.
// Reset clears all valid bits and loads weights of one and gamma 1.0.
// Configuration is written through cfg_write / cfg_index / cfg_data; the user
// must do so only while no pixel is in flight, which the block does not enforce.
module grayscale_gamma_correct_top #(
  parameter int GRAY_FRAC_BITS = gg_pkg::GRAY_FRAC_BITS
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [gg_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [gg_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  logic [gg_pkg::CHAN_W-1:0]        red,
  input  logic [gg_pkg::CHAN_W-1:0]        green,
  input  logic [gg_pkg::CHAN_W-1:0]        blue,
  input  logic                             last_in,
  output logic                             gray_valid,
  input  logic                             gray_stall,
  output logic [gg_pkg::CHAN_W-1:0]        corrected_gray,
  output logic                             last_out
);

  logic [gg_pkg::WEIGHT_W-1:0] weight_red;
  logic [gg_pkg::WEIGHT_W-1:0] weight_green;
  logic [gg_pkg::WEIGHT_W-1:0] weight_blue;
  logic [gg_pkg::GAMMA_W-1:0]  gamma_exponent;
  logic                        advance;

  // Register file; data is truncated to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      weight_red     <= gg_pkg::WEIGHT_W'(1);
      weight_green   <= gg_pkg::WEIGHT_W'(1);
      weight_blue    <= gg_pkg::WEIGHT_W'(1);
      gamma_exponent <= gg_pkg::GAMMA_W'(65536);
    end else if (cfg_write) begin
      case (gg_pkg::reg_index_t'(cfg_index))
        gg_pkg::REG_WEIGHT_RED:   weight_red     <= cfg_data[gg_pkg::WEIGHT_W-1:0];
        gg_pkg::REG_WEIGHT_GREEN: weight_green   <= cfg_data[gg_pkg::WEIGHT_W-1:0];
        gg_pkg::REG_WEIGHT_BLUE:  weight_blue    <= cfg_data[gg_pkg::WEIGHT_W-1:0];
        gg_pkg::REG_GAMMA:        gamma_exponent <= cfg_data[gg_pkg::GAMMA_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline steps whenever the output slot is free or being drained.
  assign advance     = !gray_valid || !gray_stall;
  assign pixel_stall = !advance;

  gg_datapath #(
    .GRAY_FRAC_BITS (GRAY_FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .advance        (advance),
    .in_valid       (pixel_valid),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_in        (last_in),
    .weight_red     (weight_red),
    .weight_green   (weight_green),
    .weight_blue    (weight_blue),
    .gamma_exponent (gamma_exponent),
    .out_valid      (gray_valid),
    .corrected_gray (corrected_gray),
    .last_out       (last_out)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> gray_valid && gray_stall)
    else $error("pixel channel stalled without a held result");
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    gray_valid && gray_stall |=> gray_valid && $stable(corrected_gray)
      && $stable(last_out))
    else $error("stalled gray transfer lost or changed");
  a_cfg_reset: assert property (@(posedge clk)
    rst |=> gamma_exponent == gg_pkg::GAMMA_W'(65536))
    else $error("gamma not restored at reset");

endmodule

// ===== sim/grayscale_gamma_correct_top_tb.sv =====
// Self-checking testbench for the grayscale gamma correction block.
// Depends on gg_pkg and grayscale_gamma_correct_top from the rtl folder.
`timescale 1ns / 1ps

module grayscale_gamma_correct_top_tb;

  // The pipeline is 83 stages deep; allow a generous margin around it.
  localparam int PIPE_DEPTH    = 83;
  localparam int DRAIN_CYCLES  = PIPE_DEPTH + 20;
  localparam int WATCHDOG_MAX  = 2000;
  localparam int RANDOM_ITEMS  = 1050;
  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  typedef struct packed {
    logic [gg_pkg::CHAN_W-1:0] gray;
    logic                      last;
  } gray_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_write;
  logic [gg_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [gg_pkg::CFG_DATA_W-1:0]  cfg_data;
  logic                           pixel_valid;
  logic                           pixel_stall;
  logic [gg_pkg::CHAN_W-1:0]      red;
  logic [gg_pkg::CHAN_W-1:0]      green;
  logic [gg_pkg::CHAN_W-1:0]      blue;
  logic                           last_in;
  logic                           gray_valid;
  logic                           gray_stall;
  logic [gg_pkg::CHAN_W-1:0]      corrected_gray;
  logic                           last_out;

  // Our own copy of the configuration registers.
  logic [gg_pkg::WEIGHT_W-1:0] w_red;
  logic [gg_pkg::WEIGHT_W-1:0] w_green;
  logic [gg_pkg::WEIGHT_W-1:0] w_blue;
  logic [gg_pkg::GAMMA_W-1:0]  gamma_q816;

  gray_result_t pending_grays[$];
  logic [63:0]  exp2_coef[1:30];
  int           error_count;
  int           idle_cycles;
  bit           rx_quiet;

  grayscale_gamma_correct_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .pixel_valid    (pixel_valid),
    .pixel_stall    (pixel_stall),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .last_in        (last_in),
    .gray_valid     (gray_valid),
    .gray_stall     (gray_stall),
    .corrected_gray (corrected_gray),
    .last_out       (last_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bit-serial integer square root, used only to build the exp2 coefficients.
  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem  = x;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Base-2 logarithm of a positive integer in Q.30, each square truncated.
  function automatic logic [63:0] log2_fixed(input logic [63:0] v);
    int          msb;
    logic [63:0] mant;
    logic [63:0] acc;
    msb = 0;
    while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
    mant = (msb <= 30) ? (v << (30 - msb)) : (v >> (msb - 30));
    acc  = 64'(msb) << 30;
    for (int i = 29; i >= 0; i--) begin
      mant = (mant * mant) >> 30;
      if (mant >= (64'd2 << 30)) begin
        mant   = mant >> 1;
        acc[i] = 1'b1;
      end
    end
    return acc;
  endfunction

  // Gray byte for one pixel under the current weights and gamma.
  function automatic logic [gg_pkg::CHAN_W-1:0] predict_gray(
      input logic [gg_pkg::CHAN_W-1:0] r,
      input logic [gg_pkg::CHAN_W-1:0] g,
      input logic [gg_pkg::CHAN_W-1:0] b);
    logic [63:0] wsum;
    logic [63:0] full;
    logic [63:0] dot;
    logic [63:0] q;
    logic [63:0] dlog;
    logic [63:0] prod;
    logic [63:0] whole;
    logic [63:0] frac;
    logic [63:0] mant;
    logic [63:0] res;
    wsum = 64'(w_red) + 64'(w_green) + 64'(w_blue);
    full = 64'd255 << gg_pkg::GRAY_FRAC_BITS;
    if (wsum == 0) return '0;
    if (gamma_q816 == 0) return 8'd255;
    dot = 64'(w_red) * 64'(r) + 64'(w_green) * 64'(g) + 64'(w_blue) * 64'(b);
    q   = ((dot << (gg_pkg::GRAY_FRAC_BITS + 1)) + wsum) / (2 * wsum);
    if (q >= full) return 8'd255;
    if (q == 0) return '0;
    dlog  = log2_fixed(full);
    res   = log2_fixed(q);
    dlog  = (dlog > res) ? dlog - res : 64'd0;
    prod  = (dlog * 64'(gamma_q816) + (64'd1 << 15)) >> 16;
    whole = prod >> 30;
    frac  = prod & (Q30_ONE - 1);
    if (whole > 30) return '0;
    mant = Q30_ONE;
    for (int k = 1; k <= 30; k++) begin
      if ((frac >> (30 - k)) & 64'd1) mant = (mant * exp2_coef[k] + (64'd1 << 29)) >> 30;
    end
    res = (64'd255 * mant + (64'd1 << (29 + whole))) >> (30 + whole);
    return (res > 255) ? 8'd255 : res[7:0];
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Registers are written at a falling edge and take effect at the next rising edge.
  task automatic write_reg(input gg_pkg::reg_index_t idx,
                           input logic [gg_pkg::CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      gg_pkg::REG_WEIGHT_RED:   w_red      = value[gg_pkg::WEIGHT_W-1:0];
      gg_pkg::REG_WEIGHT_GREEN: w_green    = value[gg_pkg::WEIGHT_W-1:0];
      gg_pkg::REG_WEIGHT_BLUE:  w_blue     = value[gg_pkg::WEIGHT_W-1:0];
      gg_pkg::REG_GAMMA:        gamma_q816 = value[gg_pkg::GAMMA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] wr, input logic [15:0] wg,
                            input logic [15:0] wb, input logic [23:0] gm);
    write_reg(gg_pkg::REG_WEIGHT_RED, 24'(wr));
    write_reg(gg_pkg::REG_WEIGHT_GREEN, 24'(wg));
    write_reg(gg_pkg::REG_WEIGHT_BLUE, 24'(wb));
    write_reg(gg_pkg::REG_GAMMA, gm);
  endtask

  // Wait until every expected gray byte has come back, then let the pipe settle.
  task automatic wait_drained();
    while (pending_grays.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One pixel transfer, with a random gap in front unless asked otherwise.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic lst, input bit no_gap);
    gray_result_t exp_res;
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    red         <= r;
    green       <= g;
    blue        <= b;
    last_in     <= lst;
    exp_res.gray = predict_gray(r, g, b);
    exp_res.last = lst;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pending_grays.push_back(exp_res);
    @(negedge clk);
  endtask

  task automatic end_burst();
    pixel_valid <= 1'b0;
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0);
    end_burst();
  endtask

  // Channel extremes, black and white grays and the last flag under reset config.
  task automatic test_reset_defaults();
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixel(8'd1, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd254, 8'd255, 8'd255, 1'b1, 1'b1);
    send_pixel(8'd128, 8'd64, 8'd32, 1'b0, 1'b1);
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b1, 1'b1);
    end_burst();
    wait_drained();
  endtask

  // All weights zero forces black; zero gamma forces white.
  task automatic test_special_configs();
    set_config(16'd0, 16'd0, 16'd0, 24'd65536);
    send_pixel(8'd200, 8'd100, 8'd50, 1'b0, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b1, 1'b1);
    end_burst();
    wait_drained();
    set_config(16'd1, 16'd2, 16'd3, 24'd0);
    send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    send_pixel(8'd17, 8'd99, 8'd3, 1'b1, 1'b1);
    end_burst();
    wait_drained();
  endtask

  // Maximum weights and gamma drive a dark pixel's exponent product out of range to black.
  task automatic test_extreme_configs();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
    send_pixel(8'd1, 8'd1, 8'd1, 1'b0, 1'b1);
    send_pixel(8'd250, 8'd250, 8'd250, 1'b1, 1'b1);
    send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1);
    end_burst();
    wait_drained();
    set_config(16'd0, 16'hFFFF, 16'd0, 24'd1);
    send_pixel(8'd0, 8'd1, 8'd0, 1'b1, 1'b1);
    send_pixel(8'd77, 8'd128, 8'd201, 1'b0, 1'b1);
    end_burst();
    wait_drained();
  endtask

  // Random pixels under a series of weight and gamma settings. Halfway through the
  // second setting the sender holds off until everything already sent has come out.
  task automatic test_random_pixels();
    int per_phase;
    per_phase = RANDOM_ITEMS / 7;
    set_config(16'd77, 16'd150, 16'd29, 24'd145000);
    send_random(per_phase);
    wait_drained();
    set_config(16'd1, 16'd1, 16'd1, 24'd29000);
    send_random(per_phase / 2);
    while (pending_grays.size() != 0) @(negedge clk);
    send_random(per_phase / 2);
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      set_config(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)),
                 (ph == 4) ? 24'($urandom_range(0, 16777215)) : 24'($urandom_range(0, 600000)));
      send_random(per_phase);
      wait_drained();
    end
  endtask

  // Receiver: random stalls per result, checks each transfer against the oldest expectation.
  initial begin
    int hold;
    gray_stall = 1'b1;
    rx_quiet   = 1'b0;
    @(negedge clk);
    forever begin
      hold = rx_quiet ? 0 : $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) hold = 0;
      gray_stall <= (hold != 0);
      repeat (hold) @(negedge clk);
      gray_stall <= 1'b0;
      @(posedge clk);
      while (!gray_valid) @(posedge clk);
      if (pending_grays.size() == 0) begin
        report_mismatch("unexpected gray transfer", int'(corrected_gray), -1);
      end else begin
        gray_result_t want;
        want = pending_grays.pop_front();
        if (corrected_gray !== want.gray)
          report_mismatch("corrected_gray", int'(corrected_gray), int'(want.gray));
        if (last_out !== want.last)
          report_mismatch("last_out", int'(last_out), int'(want.last));
      end
      @(negedge clk);
    end
  end

  // Watchdog: count cycles without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (pixel_valid && !pixel_stall) || (gray_valid && !gray_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_MAX) begin
      $display("grayscale_gamma_correct_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [63:0] c;
    c = Q30_ONE >> 1;
    for (int k = 1; k <= 30; k++) begin
      c = int_sqrt(c << 30);
      exp2_coef[k] = c;
    end
    error_count   = 0;
    rst           = 1'b1;
    cfg_write     = 1'b0;
    cfg_index     = gg_pkg::REG_WEIGHT_RED;
    cfg_data      = '0;
    pixel_valid   = 1'b0;
    red           = '0;
    green         = '0;
    blue          = '0;
    last_in       = 1'b0;
    w_red         = 16'd1;
    w_green       = 16'd1;
    w_blue        = 16'd1;
    gamma_q816    = 24'd65536;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_defaults();
    test_special_configs();
    test_extreme_configs();
    test_random_pixels();

    wait_drained();
    if (error_count == 0) begin
      $display("grayscale_gamma_correct_top_tb OK");
    end else begin
      $display("grayscale_gamma_correct_top_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== grayscale_gamma_correct_top.f =====
rtl/gg_pkg.sv
rtl/gg_datapath.sv
rtl/grayscale_gamma_correct_top.sv
sim/grayscale_gamma_correct_top_tb.sv
